// ===== src/exsort_pkg.sv =====
// ---------------------------------------------------------------------------
// exsort_pkg
// Shared types and codes for the exchange sorter: item structs and commands.
// ---------------------------------------------------------------------------
package exsort_pkg;

   localparam int unsigned VALUE_WIDTH = 32;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SORT   = 1'b1;

   typedef struct packed {
      logic                           cmd;
      logic signed [VALUE_WIDTH-1:0]  value;
   } exsort_req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  sorted_value;
      logic                           last;
   } exsort_rsp_type;

endpackage

// ===== src/exchange_sorter_unit.sv =====
// ---------------------------------------------------------------------------
// exchange_sorter_unit
// Stores a list of signed values and, on request, sorts it in place by
// exchange sort and streams the sorted list out, marking the last entry.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req_    | in        | req_valid/req_ready  | cmd, value
//   rsp_    | out       | rsp_valid/rsp_ready  | sorted_value, last
//
// An insert item is appended at the tail; an insert while the list is full is dropped.
// A sort keeps the sequencer busy from when it is taken until the last entry
// is emitted: the scan reads one entry per cycle through the single
// read port of the list memory.
// A stalled rsp_ side holds the sequencer at the end of an outer pass.
// New items are taken only while no sort is running; reset empties the list.
// The memory needs no clearing pass: only written entries are ever read.
// ---------------------------------------------------------------------------
module exchange_sorter_unit #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  exsort_pkg::exsort_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output exsort_pkg::exsort_rsp_type rsp_data
);
   import exsort_pkg::*;

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_PRIME  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // list memory: one write port, one registered read port
   logic signed [VALUE_WIDTH-1:0] list_mem [DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]             rd_addr;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   // control and datapath registers
   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [ADDR_W-1:0]             outer_ff, outer_in;   // position a being settled
   logic [CNT_W-1:0]              issue_ff, issue_in;   // next position b to read
   logic                          cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic signed [VALUE_WIDTH-1:0] cur_ff, cur_in;       // running value of position a
   logic                          rsp_valid_ff, rsp_valid_in;
   exsort_rsp_type                rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          emit_fire;
   logic [CNT_W-1:0]              outer_next;
   logic                          issue_more;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign outer_next = CNT_W'(outer_ff) + CNT_W'(1);
   assign issue_more = (issue_ff < count_ff);
   assign emit_fire  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      outer_in     = outer_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = outer_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_data.value;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_INSERT) begin
                  // append at the tail; drop when full
                  if (count_ff < CNT_W'(DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff != '0) begin
                  outer_in = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // read position a
            rd_addr  = outer_ff;
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            cur_in   = rd_data_ff;
            issue_in = outer_next;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // issue stage: read position b
            if (issue_more) begin
               rd_addr      = issue_ff[ADDR_W-1:0];
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[ADDR_W-1:0];
               issue_in     = issue_ff + CNT_W'(1);
            end
            // compare stage: swap when the held value is greater
            if (cmp_valid_ff && (cur_ff > rd_data_ff)) begin
               wr_en   = 1'b1;
               wr_addr = cmp_idx_ff;
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            if (!issue_more && !cmp_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // position a is final: write it back and emit it
            if (emit_fire) begin
               wr_en                    = 1'b1;
               wr_addr                  = outer_ff;
               wr_data                  = cur_ff;
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = cur_ff;
               rsp_data_in.last         = (outer_next == count_ff);
               if (outer_next == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  outer_in = outer_next[ADDR_W-1:0];
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= list_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff    <= outer_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == ST_SCAN))
      else $error("compare stage active outside scan");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("entry count changed during sort");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> (CNT_W'(outer_ff) < count_ff))
      else $error("emitting beyond the list");
`endif

endmodule

// ===== verif/exchange_sorter_unit_tb.sv =====
// ---------------------------------------------------------------------------
// exchange_sorter_unit_tb
// Self-checking bench for the exchange sorter: a directed table followed by
// random insert/sort traffic, with every emitted item compared against an
// in-bench sorted-list predictor or a typed table row's own expected items.
// ---------------------------------------------------------------------------
module exchange_sorter_unit_tb;
   import exsort_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 7;
   localparam int DEPTH          = 64;
   localparam int VW             = VALUE_WIDTH;
   localparam int RANDOM_ITEMS   = 264;
   // Items near the end of the random part run with no idling on either side.
   localparam int CALM_FROM      = 236;
   // The no-handshake limit lies well beyond a full sort of the list.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 64;

   localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};

   // One row of the directed table. A typed row carries its own expected
   // output (up to two items); all other rows take theirs from the predictor.
   typedef struct packed {
      logic          cmd;
      logic [VW-1:0] value;
      logic [7:0]    reps;
      logic          rnd;
      logic          typed;
      logic [1:0]    n_out;
      logic [VW-1:0] out0;
      logic [VW-1:0] out1;
   } step_row_type;

   localparam int PLAN_ROWS = 13;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   exsort_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   exsort_rsp_type rsp_data;

   // Predictor state: the stored list and how many entries are in use.
   logic signed [VW-1:0] held_list [DEPTH];
   int unsigned          held_count = 0;
   exsort_rsp_type       sorted_outputs_due [$];

   int           miscompare_count = 0;
   int           idle_cycles      = 0;
   bit           calm             = 1'b0;
   int           stall_left       = 0;
   int           mode_left        = 0;
   bit           stall_prone      = 1'b0;
   step_row_type plan [PLAN_ROWS];
   logic signed [VW-1:0] last_inserted = '0;

   always #(CLOCK_PERIOD/2) clock = ~clock;

   exchange_sorter_unit #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // -----------------------------------------------------------------------
   // Predictor
   // -----------------------------------------------------------------------

   // Append one value; drop it when the list is already full.
   function automatic void store_value(input logic signed [VW-1:0] v);
      if (held_count < DEPTH) begin
         held_list[held_count] = v;
         held_count++;
      end
   endfunction

   // Exchange sort in place: compare each position with every later one and
   // swap when the earlier is greater (signed). Equal values are never swapped.
   // Queue one output item per entry, last flag on the final one.
   function automatic void sort_held_list(input bit queue_outputs);
      int                   a;
      int                   b;
      int                   k;
      logic signed [VW-1:0] swap;
      exsort_rsp_type       r;
      for (a = 0; a < held_count; a++) begin
         for (b = a + 1; b < held_count; b++) begin
            if (held_list[a] > held_list[b]) begin
               swap         = held_list[a];
               held_list[a] = held_list[b];
               held_list[b] = swap;
            end
         end
      end
      if (queue_outputs) begin
         for (k = 0; k < held_count; k++) begin
            r.sorted_value = held_list[k];
            r.last         = (k == held_count - 1);
            sorted_outputs_due.push_back(r);
         end
      end
   endfunction

   function automatic void apply_item(input exsort_req_type item, input bit queue_outputs);
      if (item.cmd == CMD_INSERT) begin
         store_value(item.value);
      end else begin
         sort_held_list(queue_outputs);
      end
   endfunction

   // -----------------------------------------------------------------------
   // Stimulus helpers
   // -----------------------------------------------------------------------

   // Present one item at the falling edge, optionally after a gap, and
   // return at the rising edge that accepts it.
   task automatic offer_item(input exsort_req_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic int pick_gap();
      if (calm || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(1, 7);
   endfunction

   // Mix wide random values with small ones, extremes and repeats, so that
   // duplicates and near-boundary compares show up often.
   function automatic logic signed [VW-1:0] pick_value();
      logic signed [VW-1:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $signed($urandom_range(0, 16)) - 8;
         2: begin
            case ($urandom_range(0, 3))
               0: v = VALUE_MAX;
               1: v = VALUE_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         3: v = last_inserted;
         default: begin
            if ($urandom_range(0, 1) != 0) v = VALUE_MAX - $urandom_range(0, 3);
            else v = VALUE_MIN + $urandom_range(0, 3);
         end
      endcase
      return v;
   endfunction

   task automatic report_miscompare(input string what);
      $display("MISCOMPARE: %s", what);
      miscompare_count++;
   endtask

   // -----------------------------------------------------------------------
   // Result side: random stall bursts, switched between stall-prone and
   // stall-free stretches, and none once the run goes calm.
   // -----------------------------------------------------------------------
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_prone = ($urandom_range(0, 1) != 0);
         mode_left   = $urandom_range(20, 80);
      end
      mode_left--;
      if (stall_left == 0 && !calm && stall_prone && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -----------------------------------------------------------------------
   // Checker: compare each accepted output item against the oldest one due.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      exsort_rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_outputs_due.size() == 0) begin
            report_miscompare($sformatf("unexpected item value=%0d last=%0b",
                                        rsp_data.sorted_value, rsp_data.last));
         end else begin
            due = sorted_outputs_due.pop_front();
            if (rsp_data.sorted_value !== due.sorted_value) begin
               report_miscompare($sformatf("sorted_value got %0d want %0d",
                                           rsp_data.sorted_value, due.sorted_value));
            end
            if (rsp_data.last !== due.last) begin
               report_miscompare($sformatf("last got %0b want %0b (value %0d)",
                                           rsp_data.last, due.last, due.sorted_value));
            end
         end
      end
   end

   // Watchdog: end the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("exchange_sorter_unit: mismatch");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      exsort_req_type item;
      exsort_rsp_type r;
      int             row;
      int             rep;
      int             k;
      int             counted;

      //            cmd         value           reps rnd typed n  out0       out1
      plan = '{
         '{CMD_SORT,   {VW{1'b0}},          8'd1, 1'b0, 1'b1, 2'd0, '0,        '0},
         '{CMD_INSERT, VALUE_MAX,           8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_SORT,   {(VW/2){2'b01}},     8'd1, 1'b0, 1'b1, 2'd1, VALUE_MAX, '0},
         '{CMD_INSERT, VALUE_MIN,           8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_SORT,   {(VW/2){2'b10}},     8'd1, 1'b0, 1'b1, 2'd2, VALUE_MIN, VALUE_MAX},
         '{CMD_INSERT, {VW{1'b0}},          8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_INSERT, {VW{1'b1}},          8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_INSERT, VW'(1),              8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_INSERT, VW'(1),              8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_INSERT, VALUE_MAX,           8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_SORT,   {VW{1'b1}},          8'd1, 1'b0, 1'b0, 2'd0, '0,        '0},
         '{CMD_INSERT, {VW{1'b0}},          8'd4, 1'b1, 1'b0, 2'd0, '0,        '0},
         '{CMD_SORT,   {VW{1'b0}},          8'd1, 1'b1, 1'b0, 2'd0, '0,        '0}
      };

      // Hold reset, then release it at a falling edge.
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: walk the table. Typed rows still advance the
      // predictor's list but queue their own expected items.
      for (row = 0; row < PLAN_ROWS; row++) begin
         for (rep = 0; rep < plan[row].reps; rep++) begin
            item.cmd   = plan[row].cmd;
            item.value = plan[row].rnd ? VW'($urandom) : plan[row].value;
            offer_item(item, pick_gap());
            apply_item(item, !plan[row].typed);
            if (plan[row].typed) begin
               for (k = 0; k < plan[row].n_out; k++) begin
                  r.sorted_value = (k == 0) ? plan[row].out0 : plan[row].out1;
                  r.last         = (k == plan[row].n_out - 1);
                  sorted_outputs_due.push_back(r);
               end
            end
            @(negedge clock);
         end
      end

      // Random part: grow the list with sorts mixed in on the way, then
      // keep sorting the full list. Inserts into a full list are dropped by
      // the block and are sent now and then.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         calm = (counted >= CALM_FROM);
         if (held_count < DEPTH) begin
            item.cmd = ($urandom_range(0, 4) != 0) ? CMD_INSERT : CMD_SORT;
         end else if ($urandom_range(0, 3) == 0) begin
            item.cmd = CMD_INSERT;
         end else begin
            item.cmd = CMD_SORT;
         end
         counted++;
         item.value = (item.cmd == CMD_INSERT) ? pick_value() : VW'($urandom);
         offer_item(item, pick_gap());
         apply_item(item, 1'b1);
         if (item.cmd == CMD_INSERT) last_inserted = item.value;
         @(negedge clock);
      end
      req_valid <= 1'b0;

      // Drain what is still due, then give the block time to show any
      // stray output.
      while (sorted_outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sorted_outputs_due.size() != 0) begin
         report_miscompare($sformatf("%0d items never arrived", sorted_outputs_due.size()));
      end

      if (miscompare_count == 0) begin
         $display("exchange_sorter_unit: match");
      end else begin
         $display("exchange_sorter_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/exsort_pkg.sv
src/exchange_sorter_unit.sv
verif/exchange_sorter_unit_tb.sv
